/* rtl/tbpc_pkg.sv */
// ----------------------------------------------------------------------------
// tbpc_pkg
// Shared types and constants of the timed blind position controller.
// ----------------------------------------------------------------------------
package tbpc_pkg;

    localparam logic [31:0] FULL_Q       = 32'd6553600;
    localparam logic [31:0] HALF_Q       = 32'd32768;
    localparam logic [15:0] ENDSTOP_HOLD = 16'd3000;
    localparam logic [18:0] OVERRUN_MS   = 19'd5000;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;
    localparam logic [1:0] DIR_STOP = 2'd3;

    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_PRESS  = 2'd1;
    localparam logic [1:0] MODE_TARGET = 2'd2;
    localparam logic [1:0] MODE_STOP   = 2'd3;

    localparam logic [1:0] BTN_TOP    = 2'd0;
    localparam logic [1:0] BTN_MID    = 2'd1;
    localparam logic [1:0] BTN_BOTTOM = 2'd2;

    localparam logic [1:0] REP_NONE = 2'd0;
    localparam logic [1:0] REP_UP   = 2'd1;
    localparam logic [1:0] REP_DOWN = 2'd2;
    localparam logic [1:0] REP_STOP = 2'd3;

    localparam logic [2:0] CFG_SAFE  = 3'd0;
    localparam logic [2:0] CFG_UPT   = 3'd1;
    localparam logic [2:0] CFG_DNT   = 3'd2;
    localparam logic [2:0] CFG_SHORT = 3'd3;
    localparam logic [2:0] CFG_LONG  = 3'd4;
    localparam logic [2:0] CFG_PRE   = 3'd5;
    localparam logic [2:0] CFG_PAUSE = 3'd6;

    typedef struct packed {
        logic start;    // accept item: run the step logic
        logic div_go;   // launch the step divider
        logic out_load; // capture result register
    } cmd_t;

    typedef struct packed {
        logic need_div; // a start happened, step must be computed
        logic div_done;
    } status_t;

endpackage

/* rtl/tbpc_ctrl.sv */
// ----------------------------------------------------------------------------
// tbpc_ctrl
// Sequencer: accepts an item, waits for the step divider when a movement
// starts, then loads the result register.
// ----------------------------------------------------------------------------
module tbpc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  tbpc_pkg::status_t    status,
    output tbpc_pkg::cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CHK  = 3'b010,
        ST_DIV  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = !out_valid || out_ready;
                if (in_valid && in_ready)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                if (status.need_div)
                begin
                    cmd.div_go = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* rtl/tbpc_div.sv */
// ----------------------------------------------------------------------------
// tbpc_div
// Restoring divider, one quotient bit per cycle:
// step = (FULL_Q + d/2) / d, with d forced to 1 when zero.
// ----------------------------------------------------------------------------
module tbpc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [17:0] divisor,
    output logic        done,
    output logic [22:0] quotient
);

    logic [23:0] num_reg, num_next;
    logic [18:0] rem_reg, rem_next;
    logic [17:0] d_reg, d_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [18:0] trial;
    logic [17:0] d_eff;
    logic [23:0] dividend;

    assign d_eff    = (divisor == 18'd0) ? 18'd1 : divisor;
    assign dividend = tbpc_pkg::FULL_Q[23:0] + {7'd0, d_eff[17:1]};
    assign trial    = {rem_reg[17:0], num_reg[23]};
    assign done     = busy_reg && (cnt_reg == 5'd0);
    assign quotient = num_reg[22:0];

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (go)
        begin
            num_next  = dividend;
            rem_next  = '0;
            d_next    = d_eff;
            cnt_next  = 5'd24;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 5'd0)
                busy_next = 1'b0;
            else
            begin
                cnt_next = cnt_reg - 5'd1;
                if (trial >= {1'b0, d_reg})
                begin
                    rem_next = trial - {1'b0, d_reg};
                    num_next = {num_reg[22:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    num_next = {num_reg[22:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

endmodule

/* rtl/tbpc_dp.sv */
// ----------------------------------------------------------------------------
// tbpc_dp
// Datapath: configuration, position estimate, timers, command handling.
// ----------------------------------------------------------------------------
module tbpc_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [17:0]        cfg_data,
    input  logic [1:0]         mode,
    input  logic [1:0]         button,
    input  logic [15:0]        press_ms,
    input  logic [6:0]         target_pct,
    input  tbpc_pkg::cmd_t     cmd,
    output tbpc_pkg::status_t  status,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               motor_up,
    output logic               motor_down,
    output logic               led_up,
    output logic               led_down,
    output logic               led_pause,
    output logic [6:0]         position_pct,
    output logic [1:0]         report,
    output logic               in_motion,
    output logic               is_pending
);

    // configuration
    logic [15:0] safe_reg, short_reg, long_reg, pled_reg;
    logic [17:0] upt_reg, dnt_reg, limit_reg, limit_next;
    logic [6:0]  pre_reg;

    // block state
    logic [22:0] pos_reg, pos_next, tgt_reg, tgt_next, step_reg;
    logic [1:0]  adir_reg, adir_next, pdir_reg, pdir_next, rep_reg, rep_next;
    logic        mov_reg, mov_next, pend_reg, pend_next, pause_reg, pause_next;
    logic        esa_reg, esa_next;
    logic [15:0] est_reg, est_next;
    logic [31:0] run_reg, run_next;
    logic        ndiv_reg, ndiv_next;

    logic [22:0] quotient;
    logic        div_done;

    // output register
    logic        ov_reg;
    logic [1:0]  orep_reg;
    logic        oup_reg, odn_reg, opause_reg, omov_reg, opend_reg;
    logic [6:0]  opos_reg;

    assign status.need_div = ndiv_reg;
    assign status.div_done = div_done;

    tbpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.div_go),
        .divisor  (limit_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            safe_reg  <= 16'd500;
            upt_reg   <= 18'd30000;
            dnt_reg   <= 18'd30000;
            short_reg <= 16'd1000;
            long_reg  <= 16'd3000;
            pre_reg   <= 7'd50;
            pled_reg  <= 16'd2000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tbpc_pkg::CFG_SAFE:  safe_reg  <= cfg_data[15:0];
                tbpc_pkg::CFG_UPT:   upt_reg   <= cfg_data;
                tbpc_pkg::CFG_DNT:   dnt_reg   <= cfg_data;
                tbpc_pkg::CFG_SHORT: short_reg <= cfg_data[15:0];
                tbpc_pkg::CFG_LONG:  long_reg  <= cfg_data[15:0];
                tbpc_pkg::CFG_PRE:   pre_reg   <= cfg_data[6:0];
                tbpc_pkg::CFG_PAUSE: pled_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Step logic, evaluated on the accepted item.
    always_comb
    begin
        logic [1:0]  mdir;
        logic        mreq;
        logic        tgo;
        logic [6:0]  tpct;
        logic [22:0] nq;
        logic [22:0] diff;
        logic        shortp, midp;
        logic [22:0] pq;
        logic        skip;
        logic [31:0] tr;
        logic [23:0] sum;
        logic        stop_now;
        logic [22:0] rp;

        pos_next   = pos_reg;
        tgt_next   = tgt_reg;
        adir_next  = adir_reg;
        pdir_next  = pdir_reg;
        mov_next   = mov_reg;
        pend_next  = pend_reg;
        pause_next = pause_reg;
        esa_next   = esa_reg;
        est_next   = est_reg;
        run_next   = run_reg;
        limit_next = limit_reg;
        rep_next   = tbpc_pkg::REP_NONE;
        ndiv_next  = 1'b0;
        mdir       = tbpc_pkg::DIR_NONE;
        mreq       = 1'b0;
        tgo        = 1'b0;
        tpct       = '0;
        nq         = '0;
        diff       = '0;
        pq         = {pre_reg, 16'd0};
        shortp     = press_ms < short_reg;
        midp       = (press_ms > short_reg) && (press_ms < long_reg);
        skip       = 1'b0;
        tr         = '0;
        sum        = '0;
        stop_now   = 1'b0;
        rp         = '0;

        case (mode)
            tbpc_pkg::MODE_PRESS:
            begin
                case (button)
                    tbpc_pkg::BTN_TOP:
                    begin
                        tgo  = shortp || midp;
                        tpct = (midp && !shortp && pos_reg < pq) ? pre_reg : 7'd100;
                    end
                    tbpc_pkg::BTN_MID:
                    begin
                        mreq = shortp;
                        mdir = tbpc_pkg::DIR_STOP;
                    end
                    tbpc_pkg::BTN_BOTTOM:
                    begin
                        tgo  = shortp || midp;
                        tpct = (shortp && pos_reg > pq) ? pre_reg : 7'd0;
                    end
                    default: ;
                endcase
            end
            tbpc_pkg::MODE_TARGET:
            begin
                tgo  = 1'b1;
                tpct = target_pct;
            end
            tbpc_pkg::MODE_STOP:
            begin
                mreq = 1'b1;
                mdir = tbpc_pkg::DIR_STOP;
            end
            default:
            begin
                // tick
                tr = (run_reg == 32'hFFFF_FFFF) ? run_reg : run_reg + 32'd1;
                run_next = tr;
                if (pend_reg && tr >= {16'd0, safe_reg})
                begin
                    adir_next  = pdir_reg;
                    mov_next   = 1'b1;
                    pend_next  = 1'b0;
                    esa_next   = 1'b0;
                    est_next   = '0;
                    run_next   = '0;
                    limit_next = (pdir_reg == tbpc_pkg::DIR_UP) ? upt_reg : dnt_reg;
                    rep_next   = (pdir_reg == tbpc_pkg::DIR_UP) ?
                                 tbpc_pkg::REP_UP : tbpc_pkg::REP_DOWN;
                    ndiv_next  = 1'b1;
                end
                else if (mov_reg)
                begin
                    if (adir_reg == tbpc_pkg::DIR_UP)
                    begin
                        sum = {1'b0, pos_reg} + {1'b0, step_reg};
                        pos_next = (sum > tbpc_pkg::FULL_Q[23:0]) ?
                                   tbpc_pkg::FULL_Q[22:0] : sum[22:0];
                    end
                    else
                        pos_next = (pos_reg > step_reg) ? pos_reg - step_reg : '0;
                    if (tgt_reg < tbpc_pkg::FULL_Q[22:0] && tgt_reg != '0)
                    begin
                        if ((adir_reg == tbpc_pkg::DIR_UP && pos_next >= tgt_reg) ||
                            (adir_reg == tbpc_pkg::DIR_DOWN && pos_next <= tgt_reg))
                            stop_now = 1'b1;
                    end
                    else if ((pos_next >= tbpc_pkg::FULL_Q[22:0] &&
                              tgt_reg == tbpc_pkg::FULL_Q[22:0]) ||
                             (pos_next == '0 && tgt_reg == '0))
                    begin
                        if (!esa_reg)
                        begin
                            esa_next = 1'b1;
                            est_next = '0;
                        end
                        else if (est_reg != 16'hFFFF)
                            est_next = est_reg + 16'd1;
                        if (est_next >= tbpc_pkg::ENDSTOP_HOLD)
                        begin
                            esa_next = 1'b0;
                            est_next = '0;
                            stop_now = 1'b1;
                        end
                    end
                    else
                    begin
                        esa_next = 1'b0;
                        est_next = '0;
                    end
                    if (tr >= {13'd0, {1'b0, limit_reg} + tbpc_pkg::OVERRUN_MS})
                        stop_now = 1'b1;
                end
                // a fresh start checks the overrun against its own travel time
                if (pend_reg && tr >= {16'd0, safe_reg})
                begin
                    if (tr >= {13'd0, {1'b0, limit_next} + tbpc_pkg::OVERRUN_MS})
                        stop_now = 1'b1;
                end
                if (stop_now)
                begin
                    adir_next  = tbpc_pkg::DIR_NONE;
                    mov_next   = 1'b0;
                    pend_next  = 1'b0;
                    run_next   = '0;
                    rep_next   = tbpc_pkg::REP_STOP;
                    pause_next = 1'b1;
                    rp = (pos_next > tbpc_pkg::FULL_Q[22:0]) ?
                         tbpc_pkg::FULL_Q[22:0] : pos_next;
                    pos_next = {rp[22:16] + {6'd0, rp[15]}, 16'd0};
                end
                if (pause_next && (tr >= {16'd0, pled_reg} || mov_next))
                    pause_next = 1'b0;
            end
        endcase

        // set target: compute requested direction
        if (tgo)
        begin
            nq   = {tpct, 16'd0};
            diff = (nq > pos_reg) ? nq - pos_reg : pos_reg - nq;
            if (diff >= tbpc_pkg::HALF_Q[22:0])
            begin
                tgt_next = nq;
                if (nq > pos_reg && adir_reg != tbpc_pkg::DIR_UP)
                begin
                    mreq = 1'b1;
                    mdir = tbpc_pkg::DIR_UP;
                end
                else if (nq < pos_reg && adir_reg != tbpc_pkg::DIR_DOWN)
                begin
                    mreq = 1'b1;
                    mdir = tbpc_pkg::DIR_DOWN;
                end
            end
        end

        // move command
        if (mreq)
        begin
            if (mov_reg || mdir == tbpc_pkg::DIR_STOP || pend_reg)
            begin
                if ((adir_reg == tbpc_pkg::DIR_UP && mdir == tbpc_pkg::DIR_UP) ||
                    (adir_reg == tbpc_pkg::DIR_DOWN && mdir == tbpc_pkg::DIR_DOWN))
                    skip = 1'b1;
                else
                begin
                    adir_next = tbpc_pkg::DIR_NONE;
                    mov_next  = 1'b0;
                    pend_next = 1'b0;
                    run_next  = '0;
                    rep_next  = tbpc_pkg::REP_STOP;
                    if (mdir == tbpc_pkg::DIR_STOP)
                    begin
                        skip       = 1'b1;
                        pause_next = 1'b1;
                        rp = (pos_reg > tbpc_pkg::FULL_Q[22:0]) ?
                             tbpc_pkg::FULL_Q[22:0] : pos_reg;
                        pos_next = {rp[22:16] + {6'd0, rp[15]}, 16'd0};
                    end
                end
            end
            if (!skip)
            begin
                if (!((pos_reg == '0 && mdir == tbpc_pkg::DIR_DOWN) ||
                      (pos_reg >= tbpc_pkg::FULL_Q[22:0] && mdir == tbpc_pkg::DIR_UP)))
                begin
                    pdir_next = mdir;
                    pend_next = 1'b1;
                    if (run_next > {16'd0, safe_reg})
                        run_next = {16'd0, safe_reg};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            tgt_reg   <= '0;
            adir_reg  <= tbpc_pkg::DIR_NONE;
            pdir_reg  <= tbpc_pkg::DIR_NONE;
            mov_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            pause_reg <= 1'b0;
            esa_reg   <= 1'b0;
            est_reg   <= '0;
            run_reg   <= '0;
            limit_reg <= '0;
            rep_reg   <= tbpc_pkg::REP_NONE;
            ndiv_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                pos_reg   <= pos_next;
                tgt_reg   <= tgt_next;
                adir_reg  <= adir_next;
                pdir_reg  <= pdir_next;
                mov_reg   <= mov_next;
                pend_reg  <= pend_next;
                pause_reg <= pause_next;
                esa_reg   <= esa_next;
                est_reg   <= est_next;
                run_reg   <= run_next;
                limit_reg <= limit_next;
                rep_reg   <= rep_next;
                ndiv_reg  <= ndiv_next;
            end
            if (div_done)
                step_reg <= quotient;
        end
    end

    // result register: holds until transferred
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.out_load)
            ov_reg <= 1'b1;
        else if (out_ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            oup_reg    <= mov_reg && adir_reg == tbpc_pkg::DIR_UP;
            odn_reg    <= mov_reg && adir_reg == tbpc_pkg::DIR_DOWN;
            opause_reg <= pause_reg;
            opos_reg   <= pos_reg[22:16] + {6'd0, pos_reg[15]};
            orep_reg   <= rep_reg;
            omov_reg   <= mov_reg;
            opend_reg  <= pend_reg;
        end
    end

    assign out_valid    = ov_reg;
    assign motor_up     = oup_reg;
    assign motor_down   = odn_reg;
    assign led_up       = oup_reg;
    assign led_down     = odn_reg;
    assign led_pause    = opause_reg;
    assign position_pct = opos_reg;
    assign report       = orep_reg;
    assign in_motion    = omov_reg;
    assign is_pending   = opend_reg;

endmodule

/* rtl/timed_blind_position_controller.sv */
// ----------------------------------------------------------------------------
// timed_blind_position_controller
// Window blind relay and LED controller with time-based position estimate.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one item: a 1 ms tick, a button
// press with its duration, a set-target command or a stop command.
// Every item gives exactly one result on the output channel
// (out_valid/out_ready): relay and LED drives, rounded position, report
// code and moving/pending flags.
// After the input transfer the sequencer passes its check state and loads
// the result register; a tick that starts a movement first launches the
// bit-serial step divider and waits for its quotient before the load.
// One item is in work at a time; the next is taken once the result
// register is free or being transferred in the same cycle.
// If the receiver stalls, the result holds and no new item is taken.
// Configuration is a write port (cfg_we, cfg_index, cfg_data) used while
// idle; the user must keep to this, as the block does not enforce it.
// Reset clears the position, all timers and flags and loads the default
// configuration; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module timed_blind_position_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [17:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [1:0]  button,
    input  logic [15:0] press_ms,
    input  logic [6:0]  target_pct,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        motor_up,
    output logic        motor_down,
    output logic        led_up,
    output logic        led_down,
    output logic        led_pause,
    output logic [6:0]  position_pct,
    output logic [1:0]  report,
    output logic        in_motion,
    output logic        is_pending
);

    tbpc_pkg::cmd_t    cmd;
    tbpc_pkg::status_t status;

    tbpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    tbpc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mode         (mode),
        .button       (button),
        .press_ms     (press_ms),
        .target_pct   (target_pct),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .motor_up     (motor_up),
        .motor_down   (motor_down),
        .led_up       (led_up),
        .led_down     (led_down),
        .led_pause    (led_pause),
        .position_pct (position_pct),
        .report       (report),
        .in_motion    (in_motion),
        .is_pending   (is_pending)
    );

`ifndef SYNTHESIS
    a_relays_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(motor_up && motor_down))
        else $error("both relays driven");
    a_move_pend: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(in_motion && is_pending))
        else $error("moving and pending together");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("item taken while result stalled");
`endif

endmodule
